// ===== design/qoi_pkg.sv =====
// Shared constants, term tables and controller command type of the quaternion integrator.
`default_nettype none

package qoi_pkg;

    // Default width of one stored orientation component, signed Q2.30 at 32 bits.
    localparam int COMPONENT_WIDTH = 32;

    localparam int FIELD_W = 32;
    localparam int DT_W = 24;
    localparam int S_TDATA_W = 7 * FIELD_W + DT_W;
    localparam int M_TDATA_W = 4 * FIELD_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Sequencer: twelve Hamilton terms, then two scale products per component.
    localparam int NUM_TERMS = 12;
    localparam int NUM_STEPS = 20;
    localparam int STEP_W = 5;
    localparam int TERM_IDX_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
    localparam logic [STEP_W-1:0] FIRST_SCALE = STEP_W'(NUM_TERMS);

    localparam int OPND_W = 33;
    localparam int PROD_W = 64;
    localparam int SUM_W = 50;
    localparam int SHIFT_TERM = 16;
    localparam int SHIFT_SCALE = 25;

    // Component index: 0 = w, 1 = x, 2 = y, 3 = z. Omega index: 0 = x, 1 = y, 2 = z.
    localparam logic [1:0] TermComp [0:NUM_TERMS-1] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3
    };
    localparam logic [1:0] TermOmega [0:NUM_TERMS-1] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1
    };
    localparam logic [1:0] TermQuat [0:NUM_TERMS-1] = '{
        2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1
    };
    localparam logic TermNeg [0:NUM_TERMS-1] = '{
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
    };

    typedef struct packed {
        logic              start;
        logic              issue;
        logic [STEP_W-1:0] idx;
        logic              emit;
    } qoi_ctrl_t;

endpackage

`default_nettype wire

// ===== design/qoi_controller.sv =====
// Sequencing state machine of the quaternion integrator.
`default_nettype none

module qoi_controller (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_cmd,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output qoi_pkg::qoi_ctrl_t     ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [qoi_pkg::STEP_W-1:0]  idx_reg, idx_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        accept;
    logic                        emit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit     = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    state_next = (s_cmd == qoi_pkg::CMD_STEP) ? ST_RUN : ST_EMIT;
                end
            end
            ST_RUN: begin
                if (idx_reg == qoi_pkg::LAST_STEP) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        ctrl.start = accept;
        ctrl.issue = (state_reg == ST_RUN);
        ctrl.idx   = idx_reg;
        ctrl.emit  = emit;
    end

endmodule

`default_nettype wire

// ===== design/qoi_datapath.sv =====
// Orientation registers, shared multiplier, accumulators and saturation of the integrator.
`default_nettype none

module qoi_datapath #(
    parameter int CW = qoi_pkg::COMPONENT_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire qoi_pkg::qoi_ctrl_t              ctrl,
    input  wire logic [qoi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_cmd,
    output logic      [qoi_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_sat
);

    localparam int FW = qoi_pkg::FIELD_W;
    localparam int DTW = qoi_pkg::DT_W;
    localparam int OW = qoi_pkg::OPND_W;
    localparam int PW = qoi_pkg::PROD_W;
    localparam int SUMW = qoi_pkg::SUM_W;
    localparam int SW = ((CW > SUMW) ? CW : SUMW) + 2;
    localparam int TW = PW - qoi_pkg::SHIFT_TERM;
    localparam int HIW = SUMW - qoi_pkg::SHIFT_SCALE;
    localparam int LOW = qoi_pkg::SHIFT_SCALE;
    localparam int PLW = DTW;
    localparam int TIW = qoi_pkg::TERM_IDX_W;

    localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] CMIN = ~CMAX;
    localparam logic signed [SW-1:0] OMAX = {{(SW-FW+1){1'b0}}, {(FW-1){1'b1}}};
    localparam logic signed [SW-1:0] OMIN = ~OMAX;

    logic signed [CW-1:0]   q_reg [4];
    logic signed [FW-1:0]   om_reg [3];
    logic        [DTW-1:0]  dt_reg;
    logic signed [SUMW-1:0] sum_reg [4];
    logic signed [SUMW-1:0] d_reg;
    logic signed [PW-1:0]   prod_reg;
    logic                   tag_vld_reg;
    logic [qoi_pkg::STEP_W-1:0] tag_idx_reg;
    logic                   flag_reg;
    logic [qoi_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                   out_sat_reg;

    logic signed [SW-1:0]   qe [4];
    logic signed [FW-1:0]   opq [4];
    logic signed [CW-1:0]   load_val [4];
    logic        [3:0]      load_clip;

    // Issue side decode.
    logic                       i_term;
    logic [TIW-1:0]             i_ti;
    logic [qoi_pkg::STEP_W-1:0] i_sidx;
    logic [1:0]                 i_comp;
    logic signed [OW-1:0]       mul_a, mul_b;
    logic signed [2*OW-1:0]     mul_full;

    // Retire side decode.
    logic                       t_term;
    logic [TIW-1:0]             t_ti;
    logic [qoi_pkg::STEP_W-1:0] t_sidx;
    logic [1:0]                 t_comp;
    logic [1:0]                 t_tcomp;
    logic signed [SUMW-1:0]     term_ext;
    logic signed [SW-1:0]       upd_sum;
    logic signed [CW-1:0]       upd_val;
    logic                       upd_clip;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic signed [SW-1:0] le;
            le = {{(SW-FW){s_tdata[FW*i+FW-1]}}, s_tdata[FW*i +: FW]};
            qe[i] = {{(SW-CW){q_reg[i][CW-1]}}, q_reg[i]};
            // Multiplier operands see the state clipped to the 32-bit range.
            if (qe[i] > OMAX) begin
                opq[i] = OMAX[FW-1:0];
            end else if (qe[i] < OMIN) begin
                opq[i] = OMIN[FW-1:0];
            end else begin
                opq[i] = qe[i][FW-1:0];
            end
            if (le > CMAX) begin
                load_val[i]  = CMAX[CW-1:0];
                load_clip[i] = 1'b1;
            end else if (le < CMIN) begin
                load_val[i]  = CMIN[CW-1:0];
                load_clip[i] = 1'b1;
            end else begin
                load_val[i]  = le[CW-1:0];
                load_clip[i] = 1'b0;
            end
        end
    end

    assign i_term = ctrl.idx < qoi_pkg::FIRST_SCALE;
    assign i_ti   = ctrl.idx[TIW-1:0];
    assign i_sidx = ctrl.idx - qoi_pkg::FIRST_SCALE;
    assign i_comp = i_sidx[2:1];

    // Even scale steps multiply the upper part of the sum by dt, odd steps the lower part.
    always_comb begin
        if (i_term) begin
            mul_a = {{(OW-FW){om_reg[qoi_pkg::TermOmega[i_ti]][FW-1]}},
                     om_reg[qoi_pkg::TermOmega[i_ti]]};
            mul_b = {{(OW-FW){opq[qoi_pkg::TermQuat[i_ti]][FW-1]}},
                     opq[qoi_pkg::TermQuat[i_ti]]};
        end else if (!i_sidx[0]) begin
            mul_a = {{(OW-HIW){sum_reg[i_comp][SUMW-1]}}, sum_reg[i_comp][SUMW-1:LOW]};
            mul_b = {{(OW-DTW){1'b0}}, dt_reg};
        end else begin
            mul_a = {{(OW-LOW){1'b0}}, sum_reg[i_comp][LOW-1:0]};
            mul_b = {{(OW-DTW){1'b0}}, dt_reg};
        end
    end

    assign mul_full = mul_a * mul_b;

    assign t_term  = tag_idx_reg < qoi_pkg::FIRST_SCALE;
    assign t_ti    = tag_idx_reg[TIW-1:0];
    assign t_sidx  = tag_idx_reg - qoi_pkg::FIRST_SCALE;
    assign t_comp  = t_sidx[2:1];
    assign t_tcomp = qoi_pkg::TermComp[t_ti];

    assign term_ext = {{(SUMW-TW){prod_reg[PW-1]}}, prod_reg[PW-1:qoi_pkg::SHIFT_TERM]};

    always_comb begin
        upd_sum = qe[t_comp] + {{(SW-SUMW){d_reg[SUMW-1]}}, d_reg}
                + {{(SW-PLW){1'b0}}, prod_reg[LOW+PLW-1:LOW]};
        if (upd_sum > CMAX) begin
            upd_val  = CMAX[CW-1:0];
            upd_clip = 1'b1;
        end else if (upd_sum < CMIN) begin
            upd_val  = CMIN[CW-1:0];
            upd_clip = 1'b1;
        end else begin
            upd_val  = upd_sum[CW-1:0];
            upd_clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                q_reg[i] <= '0;
            end
            tag_vld_reg <= 1'b0;
        end else begin
            tag_vld_reg <= ctrl.issue;
            if (ctrl.start && (s_cmd == qoi_pkg::CMD_LOAD)) begin
                for (int i = 0; i < 4; i++) begin
                    q_reg[i] <= load_val[i];
                end
            end else if (tag_vld_reg && !t_term && t_sidx[0]) begin
                q_reg[t_comp] <= upd_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tag_idx_reg <= ctrl.idx;
        prod_reg    <= mul_full[PW-1:0];
        if (ctrl.start) begin
            for (int i = 0; i < 3; i++) begin
                om_reg[i] <= s_tdata[4*FW + FW*i +: FW];
            end
            dt_reg <= s_tdata[7*FW +: DTW];
            for (int i = 0; i < 4; i++) begin
                sum_reg[i] <= '0;
            end
            flag_reg <= (s_cmd == qoi_pkg::CMD_LOAD) ? (|load_clip) : 1'b0;
        end else if (tag_vld_reg) begin
            if (t_term) begin
                if (qoi_pkg::TermNeg[t_ti]) begin
                    sum_reg[t_tcomp] <= sum_reg[t_tcomp] - term_ext;
                end else begin
                    sum_reg[t_tcomp] <= sum_reg[t_tcomp] + term_ext;
                end
            end else if (!t_sidx[0]) begin
                d_reg <= prod_reg[SUMW-1:0];
            end else begin
                flag_reg <= flag_reg | upd_clip;
            end
        end
        if (ctrl.emit) begin
            for (int i = 0; i < 4; i++) begin
                out_data_reg[FW*i +: FW] <= qe[i][FW-1:0];
            end
            out_sat_reg <= flag_reg;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_sat   = out_sat_reg;

endmodule

`default_nettype wire

// ===== design/quaternion_orientation_integrator.sv =====
// Top level of the quaternion orientation integrator: controller plus datapath.
//
// Input stream (s_*): one beat per item. s_tuser is the command: 0 loads the
// orientation from the four load fields, 1 integrates one time step with the
// angular velocity and dt fields. Output stream (m_*): one beat per item with
// the new orientation (low 32 bits of each component) and the saturation flag.
//
// A step runs twenty products through one shared 33x33 multiplier: twelve
// Hamilton terms and two scale-by-dt products per component. The products are
// issued in turn in the run state, a drain state retires the last one, and the
// emit state writes the result beat; only then is the next input beat taken. A
// load goes straight from its beat to the emit state.
//
// Reset clears the orientation to zero and empties the output register. The
// result sits in an output register; while the receiver stalls it holds there,
// the block still takes the next input beat, and it waits before writing the
// next result until the held one is taken.
`default_nettype none

module quaternion_orientation_integrator #(
    parameter int COMPONENT_WIDTH = qoi_pkg::COMPONENT_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: load_w, load_x, load_y, load_z, omega_x, omega_y, omega_z, dt.
    input  wire logic [qoi_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: cmd.
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: out_w, out_x, out_y, out_z.
    output logic      [qoi_pkg::M_TDATA_W-1:0]   m_tdata,
    // Fields from bit 0: saturated.
    output logic                                 m_tuser
);

    qoi_pkg::qoi_ctrl_t ctrl;

    qoi_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    qoi_datapath #(
        .CW (COMPONENT_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_tdata (s_tdata),
        .s_cmd   (s_tuser),
        .m_tdata (m_tdata),
        .m_sat   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== bench/tb_quaternion_orientation_integrator.sv =====
// Testbench of the quaternion orientation integrator: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module tb_quaternion_orientation_integrator;

    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic [qoi_pkg::DT_W-1:0] DT_MAX = '1;

    // Input beat fields, load_w in the lowest bits.
    typedef struct packed {
        logic [qoi_pkg::DT_W-1:0] dt;
        logic signed [31:0] omega_z;
        logic signed [31:0] omega_y;
        logic signed [31:0] omega_x;
        logic signed [31:0] load_z;
        logic signed [31:0] load_y;
        logic signed [31:0] load_x;
        logic signed [31:0] load_w;
    } orient_item_t;

    // Result beat: the saturated flag sits above the four components.
    typedef struct packed {
        logic               sat;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic signed [31:0] w;
    } orient_out_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [qoi_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [qoi_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    orient_out_t expected_orient[$];
    longint      orient_q[4];
    int          mismatches = 0;
    int          result_beats = 0;
    int          recv_stall = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    quaternion_orientation_integrator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_range(longint v, longint lo, longint hi, inout logic flag);
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint clamp_component(longint v, inout logic flag);
        longint hi;
        hi = (longint'(1) <<< (qoi_pkg::COMPONENT_WIDTH - 1)) - 1;
        return clamp_range(v, -hi - 1, hi, flag);
    endfunction

    // Floored Q18.30 product of a rate and a component.
    function automatic longint hamilton_term(longint o, longint q);
        return (o * q) >>> qoi_pkg::SHIFT_TERM;
    endfunction

    // floor(s * dt / 2^25): the product needs more than 64 bits.
    function automatic longint scale_by_half_dt(longint s, logic [qoi_pkg::DT_W-1:0] dt);
        logic signed [79:0] s_wide;
        logic signed [79:0] dt_wide;
        logic signed [79:0] prod;
        s_wide  = s;
        dt_wide = {56'd0, dt};
        prod    = (s_wide * dt_wide) >>> qoi_pkg::SHIFT_SCALE;
        return longint'(prod);
    endfunction

    function automatic orient_out_t advance_orientation(logic cmd, orient_item_t it);
        longint      ox, oy, oz;
        longint      opnd[4];
        longint      rate[4];
        logic        dummy;
        orient_out_t r;
        r.sat = 1'b0;
        dummy = 1'b0;
        if (cmd == qoi_pkg::CMD_LOAD) begin
            orient_q[0] = clamp_component(longint'(it.load_w), r.sat);
            orient_q[1] = clamp_component(longint'(it.load_x), r.sat);
            orient_q[2] = clamp_component(longint'(it.load_y), r.sat);
            orient_q[3] = clamp_component(longint'(it.load_z), r.sat);
        end else begin
            ox = it.omega_x;
            oy = it.omega_y;
            oz = it.omega_z;
            // Wide components feed the multiplier clipped to 32 bits, without flagging.
            foreach (opnd[i])
                opnd[i] = clamp_range(orient_q[i], -64'sh8000_0000, 64'sh7FFF_FFFF, dummy);
            rate[0] = -hamilton_term(ox, opnd[1]) - hamilton_term(oy, opnd[2])
                      - hamilton_term(oz, opnd[3]);
            rate[1] = hamilton_term(ox, opnd[0]) + hamilton_term(oy, opnd[3])
                      - hamilton_term(oz, opnd[2]);
            rate[2] = hamilton_term(oy, opnd[0]) + hamilton_term(oz, opnd[1])
                      - hamilton_term(ox, opnd[3]);
            rate[3] = hamilton_term(oz, opnd[0]) + hamilton_term(ox, opnd[2])
                      - hamilton_term(oy, opnd[1]);
            foreach (orient_q[i])
                orient_q[i] = clamp_component(orient_q[i] + scale_by_half_dt(rate[i], it.dt),
                                              r.sat);
        end
        r.w = orient_q[0][31:0];
        r.x = orient_q[1][31:0];
        r.y = orient_q[2][31:0];
        r.z = orient_q[3][31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and the comparison
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] beat %0d: %s", $realtime, result_beats, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        orient_out_t got;
        orient_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (expected_orient.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
            end else begin
                want = expected_orient.pop_front();
                if (got.w !== want.w)
                    report_mismatch($sformatf("w got %h want %h", got.w, want.w));
                if (got.x !== want.x)
                    report_mismatch($sformatf("x got %h want %h", got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("y got %h want %h", got.y, want.y));
                if (got.z !== want.z)
                    report_mismatch($sformatf("z got %h want %h", got.z, want.z));
                if (got.sat !== want.sat)
                    report_mismatch($sformatf("saturated got %b want %b", got.sat, want.sat));
            end
            result_beats++;
            recv_stall = recv_calm ? 0 : $urandom_range(0, 6);
        end else if (recv_stall > 0) begin
            recv_stall--;
        end
        m_tready <= (recv_stall == 0);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    task automatic send_item(input logic cmd, input orient_item_t it);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        expected_orient.push_back(advance_orientation(cmd, it));
    endtask

    function automatic logic [qoi_pkg::DT_W-1:0] DT_DT_rand();
        logic [31:0] r;
        r = $urandom;
        return r[qoi_pkg::DT_W-1:0];
    endfunction

    function automatic orient_item_t random_fields();
        orient_item_t it;
        it.load_w  = $urandom;
        it.load_x  = $urandom;
        it.load_y  = $urandom;
        it.load_z  = $urandom;
        it.omega_x = $urandom;
        it.omega_y = $urandom;
        it.omega_z = $urandom;
        it.dt      = DT_DT_rand();
        return it;
    endfunction

    // The unused fields of each beat carry random bits.
    task automatic load_orient(input logic signed [31:0] w, x, y, z);
        orient_item_t it;
        it = random_fields();
        it.load_w = w;
        it.load_x = x;
        it.load_y = y;
        it.load_z = z;
        send_item(qoi_pkg::CMD_LOAD, it);
    endtask

    task automatic step_orient(input logic signed [31:0] ox, oy, oz,
                               input logic [qoi_pkg::DT_W-1:0] dt);
        orient_item_t it;
        it = random_fields();
        it.omega_x = ox;
        it.omega_y = oy;
        it.omega_z = oz;
        it.dt      = dt;
        send_item(qoi_pkg::CMD_STEP, it);
    endtask

    function automatic logic signed [31:0] near_zero(int unsigned mag);
        return 32'(longint'($urandom_range(0, 2 * mag)) - longint'(mag));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The orientation clears on reset, so any step before a load stays at zero.
    task automatic test_reset_state();
        step_orient(Q_MAX, Q_MIN, 32'sh1234_5678, DT_MAX);
    endtask

    task automatic test_load_extremes();
        load_orient(Q_MAX, Q_MIN, 32'sd0, -32'sd1);
        load_orient(Q_MIN, Q_MAX, 32'sd1, 32'sd0);
        load_orient(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        load_orient(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    endtask

    task automatic test_zero_dt();
        load_orient(Q_ONE, 32'sh1000_0000, -32'sh2000_0000, 32'sh0800_0000);
        step_orient(Q_MAX, Q_MIN, Q_MAX, '0);
        step_orient(Q_MIN, Q_MAX, Q_MIN, '0);
    endtask

    task automatic test_unit_rotation();
        load_orient(Q_ONE, 32'sd0, 32'sd0, 32'sd0);
        step_orient(32'sh0001_0000, 32'sd0, 32'sd0, DT_MAX);
        step_orient(32'sd0, -32'sh0001_0000, 32'sd0, DT_MAX);
        step_orient(32'sd0, 32'sd0, 32'sh0003_0000, 24'h10_0000);
        step_orient(Q_MAX, Q_MAX, Q_MAX, 24'd1);
        step_orient(Q_MIN, Q_MIN, Q_MIN, 24'd1);
        step_orient(-32'sd1, 32'sd1, -32'sd1, 24'd3);
    endtask

    task automatic test_saturation();
        load_orient(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        step_orient(Q_MAX, Q_MAX, Q_MAX, DT_MAX);
        load_orient(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        step_orient(Q_MIN, Q_MIN, Q_MIN, DT_MAX);
        load_orient(Q_ONE, 32'sd0, 32'sd0, 32'sd0);
        step_orient(Q_MIN, Q_MAX, 32'sd0, DT_MAX);
    endtask

    // Chunks of beats: most start from a plausible orientation and integrate
    // moderate rates, some use fully random fields.
    task automatic test_random_mix();
        bit          wild;
        int unsigned rate_mag;
        for (int chunk = 0; chunk < 15; chunk++) begin
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            wild      = ($urandom_range(0, 4) == 0);
            rate_mag  = 1 << $urandom_range(12, 22);
            if (wild)
                load_orient($urandom, $urandom, $urandom, $urandom);
            else
                load_orient(near_zero(Q_ONE), near_zero(Q_ONE), near_zero(Q_ONE),
                            near_zero(Q_ONE));
            for (int n = 1; n < 50; n++) begin
                if ($urandom_range(0, 99) < 12) begin
                    if (wild || $urandom_range(0, 3) == 0)
                        load_orient($urandom, $urandom, $urandom, $urandom);
                    else
                        load_orient(near_zero(Q_ONE), near_zero(Q_ONE), near_zero(Q_ONE),
                                    near_zero(Q_ONE));
                end else if (wild || $urandom_range(0, 9) == 0) begin
                    step_orient($urandom, $urandom, $urandom, DT_DT_rand());
                end else begin
                    step_orient(near_zero(rate_mag), near_zero(rate_mag), near_zero(rate_mag),
                                $urandom_range(0, 3) == 0 ? DT_DT_rand()
                                    : 24'($urandom_range(0, 24'h4_0000)));
                end
            end
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    task automatic finish_run();
        s_tvalid <= 1'b0;
        while (expected_orient.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    endtask

    initial begin
        foreach (orient_q[i])
            orient_q[i] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_load_extremes();
        test_zero_dt();
        test_unit_rotation();
        test_saturation();
        test_random_mix();
        finish_run();
    end

endmodule

// ===== files.f =====
design/qoi_pkg.sv
design/qoi_controller.sv
design/qoi_datapath.sv
design/quaternion_orientation_integrator.sv
bench/tb_quaternion_orientation_integrator.sv
